// ===== hdl/hrd_pkg.sv =====
// ----------------------------------------------------------------------------
// hrd_pkg
// Shared types and constants of the HID report to make/break event bridge.
// ----------------------------------------------------------------------------
package hrd_pkg;

	localparam int SLOTS         = 4;
	localparam int KEY_POSITIONS = 6;

	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int KEYS_W = 8 * KEY_POSITIONS;
	// step counter covers press/release of every key position and the eight modifier steps
	localparam int STEP_W = (2 * KEY_POSITIONS > 8) ? $clog2(2 * KEY_POSITIONS) : 3;
	localparam int POS_W  = STEP_W - 1;

	localparam logic [STEP_W-1:0] STEP_KEY_LAST = STEP_W'(2 * KEY_POSITIONS - 1);
	localparam logic [STEP_W-1:0] STEP_MOD_LAST = STEP_W'(7);
	localparam logic [STEP_W-1:0] STEP_BTN_LAST = STEP_W'(2);

	localparam logic [1:0] CMD_KBD   = 2'd0;
	localparam logic [1:0] CMD_MOUSE = 2'd1;
	localparam logic [1:0] CMD_DISC  = 2'd2;
	localparam logic [1:0] CMD_CLEAR = 2'd3;

	localparam logic [2:0] EV_KEY    = 3'd0;
	localparam logic [2:0] EV_MOD    = 3'd1;
	localparam logic [2:0] EV_BTN    = 3'd2;
	localparam logic [2:0] EV_MOTION = 3'd3;
	localparam logic [2:0] EV_LED    = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_KEYS,
		ST_MODS,
		ST_LED,
		ST_BTNS,
		ST_MOTION,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic [2:0]        kind;
		logic [7:0]        code;
		logic              is_press;
		logic signed [7:0] motion_x;
		logic signed [7:0] motion_y;
		logic              led_caps;
	} event_t;

	// sequencer to output stage
	typedef struct packed {
		logic   push;
		logic   finish;
		event_t evt;
	} queue_req_t;

	// output stage to sequencer
	typedef struct packed {
		logic push_ok;
		logic flush_ok;
	} queue_rsp_t;

endpackage

// ===== hdl/hrd_in_if.sv =====
// ----------------------------------------------------------------------------
// hrd_in_if
// Report channel: one HID report or slot command per item.
// ----------------------------------------------------------------------------
interface hrd_in_if;
	logic                     valid;
	logic                     ready;
	logic [1:0]               command;
	logic [3:0]               slot;
	logic [7:0]               modifier_bits;
	logic [47:0]              keycodes;
	logic                     has_led_sink;
	logic                     caps_lock_on;
	logic [2:0]               mouse_buttons;
	logic signed [7:0]        move_x;
	logic signed [7:0]        move_y;

	modport source (
		output valid, command, slot, modifier_bits, keycodes, has_led_sink,
			caps_lock_on, mouse_buttons, move_x, move_y,
		input  ready
	);

	modport sink (
		input  valid, command, slot, modifier_bits, keycodes, has_led_sink,
			caps_lock_on, mouse_buttons, move_x, move_y,
		output ready
	);
endinterface

// ===== hdl/hrd_out_if.sv =====
// ----------------------------------------------------------------------------
// hrd_out_if
// Event channel: one make/break, motion or LED event per item.
// ----------------------------------------------------------------------------
interface hrd_out_if;
	logic              valid;
	logic              ready;
	logic [2:0]        event_kind;
	logic [7:0]        event_code;
	logic              is_press;
	logic signed [7:0] motion_x;
	logic signed [7:0] motion_y;
	logic              led_caps;
	logic              last_event;

	modport source (
		output valid, event_kind, event_code, is_press, motion_x, motion_y,
			led_caps, last_event,
		input  ready
	);

	modport sink (
		input  valid, event_kind, event_code, is_press, motion_x, motion_y,
			led_caps, last_event,
		output ready
	);
endinterface

// ===== hdl/hid_report_diff_event_bridge.sv =====
// ----------------------------------------------------------------------------
// hid_report_diff_event_bridge
// Turns HID boot keyboard and mouse reports into make/break events by
// comparing each report with the last one saved for its slot.
// ----------------------------------------------------------------------------
// path: item captured into working copies, then hold stage, then output register;
//   each event waits in the hold stage until the next event or the item's end
// throughput: one diff step per cycle through the shared compare unit unless
//   the output stalls; keyboard: keys, modifiers, LED; mouse: buttons, motion;
//   disconnect: keys, modifiers, buttons; slot reset or invalid slot: none
// reset: all slots clear to zero at once, no events pending
// ----------------------------------------------------------------------------
module hid_report_diff_event_bridge
	import hrd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	hrd_in_if.sink    req,
	hrd_out_if.source evt
);

	state_t            state_q;
	state_t            state_d;
	logic [STEP_W-1:0] step_q;
	logic [STEP_W-1:0] step_d;
	logic [1:0]        cmd_q;

	logic [7:0]        sv_mods_q [SLOTS];
	logic [KEYS_W-1:0] sv_keys_q [SLOTS];
	logic [2:0]        sv_btns_q [SLOTS];
	logic              sv_led_q  [SLOTS];

	logic [7:0]        old_mods_q;
	logic [KEYS_W-1:0] old_keys_q;
	logic [2:0]        old_btns_q;
	logic              old_led_q;
	logic [7:0]        new_mods_q;
	logic [KEYS_W-1:0] new_keys_q;
	logic [2:0]        new_btns_q;
	logic              caps_q;
	logic              sink_q;
	logic signed [7:0] mx_q;
	logic signed [7:0] my_q;

	logic              take;
	logic              slot_ok;
	logic [SLOT_W-1:0] sidx;
	logic              cand_valid;
	event_t            cand;
	logic              advance;
	queue_req_t        qreq;
	queue_rsp_t        qrsp;

	assign req.ready = state_q == ST_IDLE;
	assign take      = req.valid && req.ready;
	assign slot_ok   = {1'b0, req.slot} < 5'(SLOTS);
	assign sidx      = req.slot[SLOT_W-1:0];

	hrd_step_unit u_step (
		.state      (state_q),
		.step       (step_q),
		.old_mods   (old_mods_q),
		.old_keys   (old_keys_q),
		.old_btns   (old_btns_q),
		.old_led    (old_led_q),
		.new_mods   (new_mods_q),
		.new_keys   (new_keys_q),
		.new_btns   (new_btns_q),
		.caps       (caps_q),
		.sink       (sink_q),
		.mx         (mx_q),
		.my         (my_q),
		.cand_valid (cand_valid),
		.cand       (cand)
	);

	hrd_event_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (qreq),
		.rsp    (qrsp),
		.evt    (evt)
	);

	// sequencer outputs
	always_comb begin
		qreq.push   = cand_valid;
		qreq.finish = state_q == ST_FLUSH;
		qreq.evt    = cand;
		advance     = !cand_valid || qrsp.push_ok;
	end

	// next state
	always_comb begin
		state_d = state_q;
		step_d  = step_q;
		unique case (state_q)
			ST_IDLE: begin
				step_d = '0;
				if (take && slot_ok) begin
					if (req.command == CMD_KBD || req.command == CMD_DISC) begin
						state_d = ST_KEYS;
					end else if (req.command == CMD_MOUSE) begin
						state_d = ST_BTNS;
					end
				end
			end
			ST_KEYS: begin
				if (advance) begin
					if (step_q == STEP_KEY_LAST) begin
						state_d = ST_MODS;
						step_d  = '0;
					end else begin
						step_d = step_q + STEP_W'(1);
					end
				end
			end
			ST_MODS: begin
				if (advance) begin
					if (step_q == STEP_MOD_LAST) begin
						state_d = (cmd_q == CMD_KBD) ? ST_LED : ST_BTNS;
						step_d  = '0;
					end else begin
						step_d = step_q + STEP_W'(1);
					end
				end
			end
			ST_LED: begin
				if (advance) begin
					state_d = ST_FLUSH;
				end
			end
			ST_BTNS: begin
				if (advance) begin
					if (step_q == STEP_BTN_LAST) begin
						state_d = (cmd_q == CMD_MOUSE) ? ST_MOTION : ST_FLUSH;
						step_d  = '0;
					end else begin
						step_d = step_q + STEP_W'(1);
					end
				end
			end
			ST_MOTION: begin
				if (advance) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (qrsp.flush_ok) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			cmd_q   <= CMD_KBD;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			if (take) begin
				cmd_q <= req.command;
			end
		end
	end

	// slot store, updated as soon as the old copy is captured
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < SLOTS; s++) begin
				sv_mods_q[s] <= '0;
				sv_keys_q[s] <= '0;
				sv_btns_q[s] <= '0;
				sv_led_q[s]  <= 1'b0;
			end
		end else if (take && slot_ok) begin
			unique case (req.command)
				CMD_KBD: begin
					sv_mods_q[sidx] <= req.modifier_bits;
					sv_keys_q[sidx] <= req.keycodes[KEYS_W-1:0];
					sv_led_q[sidx]  <= req.caps_lock_on;
				end
				CMD_MOUSE: begin
					sv_btns_q[sidx] <= req.mouse_buttons;
				end
				CMD_DISC, CMD_CLEAR: begin
					sv_mods_q[sidx] <= '0;
					sv_keys_q[sidx] <= '0;
					sv_btns_q[sidx] <= '0;
					sv_led_q[sidx]  <= 1'b0;
				end
				default: begin
					sv_led_q[sidx] <= sv_led_q[sidx];
				end
			endcase
		end
	end

	// working copies of the old and new report
	always_ff @(posedge clk) begin
		if (take && slot_ok) begin
			old_mods_q <= sv_mods_q[sidx];
			old_keys_q <= sv_keys_q[sidx];
			old_btns_q <= sv_btns_q[sidx];
			old_led_q  <= sv_led_q[sidx];
			caps_q     <= req.caps_lock_on;
			sink_q     <= req.has_led_sink;
			mx_q       <= req.move_x;
			my_q       <= req.move_y;
			// disconnect diffs against an empty report
			if (req.command == CMD_DISC) begin
				new_mods_q <= '0;
				new_keys_q <= '0;
				new_btns_q <= '0;
			end else begin
				new_mods_q <= req.modifier_bits;
				new_keys_q <= req.keycodes[KEYS_W-1:0];
				new_btns_q <= req.mouse_buttons;
			end
		end
	end

endmodule

// ===== hdl/hrd_step_unit.sv =====
// ----------------------------------------------------------------------------
// hrd_step_unit
// Shared compare unit: evaluates one step of the report diff and tells
// whether it yields an event, and which.
// ----------------------------------------------------------------------------
module hrd_step_unit
	import hrd_pkg::*;
(
	input  state_t            state,
	input  logic [STEP_W-1:0] step,
	input  logic [7:0]        old_mods,
	input  logic [KEYS_W-1:0] old_keys,
	input  logic [2:0]        old_btns,
	input  logic              old_led,
	input  logic [7:0]        new_mods,
	input  logic [KEYS_W-1:0] new_keys,
	input  logic [2:0]        new_btns,
	input  logic              caps,
	input  logic              sink,
	input  logic signed [7:0] mx,
	input  logic signed [7:0] my,
	output logic              cand_valid,
	output event_t            cand
);

	function automatic logic key_held(input logic [KEYS_W-1:0] keys, input logic [7:0] code);
		logic hit;
		hit = 1'b0;
		for (int p = 0; p < KEY_POSITIONS; p++) begin
			if (keys[8*p +: 8] == code) begin
				hit = 1'b1;
			end
		end
		return hit;
	endfunction

	logic [POS_W-1:0] pos;
	logic [7:0]       new_key;
	logic [7:0]       old_key;
	logic [2:0]       bit_idx;
	logic [7:0]       mask;
	logic             nb;
	logic             ob;
	logic [1:0]       btn_idx;
	logic [2:0]       btn_mask;

	assign pos     = step[STEP_W-1:1];
	assign new_key = new_keys[8*pos +: 8];
	assign old_key = old_keys[8*pos +: 8];
	assign bit_idx = step[2:0];
	assign btn_idx = step[1:0];

	always_comb begin
		mask = 8'h01 << bit_idx;
		// merged ctrl on step zero, single modifier bits after it
		if (bit_idx == 3'd0) begin
			nb = (new_mods & 8'h11) != 8'h00;
			ob = (old_mods & 8'h11) != 8'h00;
		end else begin
			nb = (new_mods & mask) != 8'h00;
			ob = (old_mods & mask) != 8'h00;
		end
	end

	// button order left, middle, right maps onto hid bits 0, 2, 1
	always_comb begin
		case (btn_idx)
			2'd0:    btn_mask = 3'b001;
			2'd1:    btn_mask = 3'b100;
			default: btn_mask = 3'b010;
		endcase
	end

	always_comb begin
		cand_valid = 1'b0;
		cand       = '0;
		unique case (state)
			ST_KEYS: begin
				cand.kind = EV_KEY;
				if (!step[0]) begin
					cand.code     = new_key;
					cand.is_press = 1'b1;
					cand_valid    = (new_key != 8'h00) && !key_held(old_keys, new_key);
				end else begin
					cand.code     = old_key;
					cand.is_press = 1'b0;
					cand_valid    = (old_key != 8'h00) && !key_held(new_keys, old_key);
				end
			end
			ST_MODS: begin
				cand.kind     = EV_MOD;
				cand.code     = mask;
				cand.is_press = nb;
				cand_valid    = nb != ob;
			end
			ST_LED: begin
				cand.kind     = EV_LED;
				cand.led_caps = caps;
				cand_valid    = sink && (old_led != caps);
			end
			ST_BTNS: begin
				cand.kind     = EV_BTN;
				cand.code     = {6'd0, btn_idx};
				cand.is_press = (new_btns & btn_mask) != 3'b000;
				cand_valid    = ((new_btns & btn_mask) != 3'b000) !=
					((old_btns & btn_mask) != 3'b000);
			end
			ST_MOTION: begin
				cand.kind     = EV_MOTION;
				cand.motion_x = mx;
				cand.motion_y = my;
				cand_valid    = (mx != 8'sd0) || (my != 8'sd0);
			end
			default: begin
				cand_valid = 1'b0;
			end
		endcase
	end

endmodule

// ===== hdl/hrd_event_queue.sv =====
// ----------------------------------------------------------------------------
// hrd_event_queue
// Holds the newest event back by one so the final event of an item can be
// marked, and drives the output register.
// ----------------------------------------------------------------------------
module hrd_event_queue
	import hrd_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  queue_req_t   req,
	output queue_rsp_t   rsp,
	hrd_out_if.source    evt
);

	logic   hold_valid_q;
	event_t hold_q;
	logic   out_valid_q;
	event_t out_q;
	logic   out_last_q;
	logic   out_free;
	logic   move_out;

	assign out_free     = !out_valid_q || evt.ready;
	assign rsp.push_ok  = !hold_valid_q || out_free;
	assign rsp.flush_ok = !hold_valid_q || out_free;
	// held item leaves when displaced by a newer one or at the end of the item
	assign move_out     = hold_valid_q && out_free && (req.push || req.finish);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (req.push && rsp.push_ok) begin
				hold_valid_q <= 1'b1;
			end else if (move_out) begin
				hold_valid_q <= 1'b0;
			end
			if (move_out) begin
				out_valid_q <= 1'b1;
			end else if (evt.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.push && rsp.push_ok) begin
			hold_q <= req.evt;
		end
		if (move_out) begin
			out_q      <= hold_q;
			out_last_q <= !req.push;
		end
	end

	assign evt.valid      = out_valid_q;
	assign evt.event_kind = out_q.kind;
	assign evt.event_code = out_q.code;
	assign evt.is_press   = out_q.is_press;
	assign evt.motion_x   = out_q.motion_x;
	assign evt.motion_y   = out_q.motion_y;
	assign evt.led_caps   = out_q.led_caps;
	assign evt.last_event = out_last_q;

endmodule
